[src/ipbf_pkg.sv]
// ipbf_pkg: shared types, prefix tables and mask helpers for the IP prefix
// blocklist filter. No dependencies.
`default_nettype none

package ipbf_pkg;

  localparam int unsigned V4_COUNT = 10;
  localparam int unsigned V6_COUNT = 7;

  typedef enum logic [2:0] {
    VERDICT_ALLOWED = 3'd0,
    VERDICT_FORCED  = 3'd1,
    VERDICT_INVALID = 3'd2,
    VERDICT_V4_HIT  = 3'd3,
    VERDICT_V6_HIT  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] entry;
    logic [7:0] plen;
  } match_t;

  localparam logic [31:0] V4_NET [V4_COUNT] = '{
    32'h0000_0000, 32'h0A00_0000, 32'h6440_0000, 32'hAC10_0000, 32'hC0A8_0000,
    32'h7F00_0000, 32'hA9FE_0000, 32'hC612_0000, 32'hE000_0000, 32'hF000_0000
  };
  localparam logic [7:0] V4_LEN [V4_COUNT] = '{
    8'd8, 8'd8, 8'd10, 8'd12, 8'd16, 8'd8, 8'd16, 8'd15, 8'd4, 8'd4
  };

  localparam logic [63:0] V6_HI [V6_COUNT] = '{
    64'h0000_0000_0000_0000, 64'h0064_FF9B_0000_0000, 64'h0100_0000_0000_0000,
    64'hFC00_0000_0000_0000, 64'hFE80_0000_0000_0000, 64'hFF00_0000_0000_0000,
    64'h0000_0000_0000_0000
  };
  localparam logic [63:0] V6_LO [V6_COUNT] = '{
    64'h0000_0000_0000_0001, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
    64'h0000_FFFF_0000_0000
  };
  localparam logic [7:0] V6_LEN [V6_COUNT] = '{
    8'd128, 8'd96, 8'd64, 8'd7, 8'd10, 8'd8, 8'd96
  };

  // ::ffff:0:0/96 upper word of the low half
  localparam logic [31:0] MAPPED_TAG = 32'h0000_FFFF;

  function automatic logic [31:0] mask32(input logic [7:0] len);
    logic [31:0] m;
    if (len == 8'd0) begin
      m = '0;
    end else if (len >= 8'd32) begin
      m = '1;
    end else begin
      m = 32'hFFFF_FFFF << (8'd32 - len);
    end
    return m;
  endfunction

  function automatic logic [63:0] mask64(input logic [7:0] len);
    logic [63:0] m;
    if (len == 8'd0) begin
      m = '0;
    end else if (len >= 8'd64) begin
      m = '1;
    end else begin
      m = 64'hFFFF_FFFF_FFFF_FFFF << (8'd64 - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/ip_prefix_blocklist_filter.sv]
// Top level of the IP prefix blocklist filter. An accepted request passes through the input
// register, then the result register, to result valid. Throughput: one request per cycle,
// stalled while rsp_stall holds a full result register; the result register advances whenever
// it is empty or being taken, and the input register refills in the same cycle.
// Reset: synchronous, active high; clears both valid flags and force_block_all.
// Depends on ipbf_pkg, ipbf_v4_match, ipbf_v6_match.
`default_nettype none

module ip_prefix_blocklist_filter
  import ipbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [63:0] addr_high,
  input  wire logic [63:0] addr_low,
  input  wire logic        addr_valid,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             allowed,
  output logic [2:0]       verdict,
  output logic [3:0]       hit_entry,
  output logic [7:0]       hit_prefix_len
);

  logic        force_block_all;
  logic        s1_valid;
  logic [63:0] s1_high;
  logic [63:0] s1_low;
  logic        s1_addr_valid;
  logic        out_load;
  logic        s1_load;
  logic        mapped;
  match_t      v4_res;
  match_t      v6_res;
  verdict_t    verdict_next;
  logic [3:0]  entry_next;
  logic [7:0]  plen_next;
  verdict_t    verdict_q;

  assign out_load  = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !out_load;
  assign s1_load   = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_block_all <= 1'b0;
    end else if (cfg_write) begin
      force_block_all <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_high       <= addr_high;
      s1_low        <= addr_low;
      s1_addr_valid <= addr_valid;
    end
  end

  assign mapped = (s1_high == 64'h0) && (s1_low[63:32] == MAPPED_TAG);

  ipbf_v4_match u_v4 (
    .addr   (s1_low[31:0]),
    .result (v4_res)
  );

  ipbf_v6_match u_v6 (
    .addr_high (s1_high),
    .addr_low  (s1_low),
    .result    (v6_res)
  );

  always_comb begin
    verdict_next = VERDICT_ALLOWED;
    entry_next   = '0;
    plen_next    = '0;
    if (force_block_all) begin
      verdict_next = VERDICT_FORCED;
    end else if (!s1_addr_valid) begin
      verdict_next = VERDICT_INVALID;
    end else if (mapped) begin
      if (v4_res.hit) begin
        verdict_next = VERDICT_V4_HIT;
        entry_next   = v4_res.entry;
        plen_next    = v4_res.plen;
      end
    end else if (v6_res.hit) begin
      verdict_next = VERDICT_V6_HIT;
      entry_next   = v6_res.entry;
      plen_next    = v6_res.plen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      verdict_q      <= verdict_next;
      hit_entry      <= entry_next;
      hit_prefix_len <= plen_next;
    end
  end

  assign verdict = verdict_q;
  assign allowed = (verdict_q == VERDICT_ALLOWED);

`ifndef SYNTHESIS
  a_req_to_s1: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> s1_valid)
    else $error("accepted request not held in input register");

  a_s1_to_rsp: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> rsp_valid)
    else $error("input register advanced without a result");

  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (verdict == VERDICT_V4_HIT || verdict == VERDICT_V6_HIT))
      |-> (hit_prefix_len != 8'd0))
    else $error("prefix hit with zero prefix length");
`endif

endmodule

`default_nettype wire

[src/ipbf_v4_match.sv]
// ipbf_v4_match: first-hit search of an IPv4 address over the fixed IPv4 list.
// Depends on ipbf_pkg.
`default_nettype none

module ipbf_v4_match
  import ipbf_pkg::*;
(
  input  wire logic [31:0] addr,
  output match_t           result
);

  logic [V4_COUNT-1:0] hits;

  always_comb begin
    for (int k = 0; k < V4_COUNT; k++) begin
      hits[k] = ((addr & mask32(V4_LEN[k])) == (V4_NET[k] & mask32(V4_LEN[k])));
    end
  end

  // lowest index wins
  always_comb begin
    result = '0;
    for (int k = V4_COUNT - 1; k >= 0; k--) begin
      if (hits[k]) begin
        result.hit   = 1'b1;
        result.entry = 4'(k);
        result.plen  = V4_LEN[k];
      end
    end
  end

endmodule

`default_nettype wire

[src/ipbf_v6_match.sv]
// ipbf_v6_match: first-hit search of a 128-bit address over the fixed IPv6 list.
// Depends on ipbf_pkg.
`default_nettype none

module ipbf_v6_match
  import ipbf_pkg::*;
(
  input  wire logic [63:0] addr_high,
  input  wire logic [63:0] addr_low,
  output match_t           result
);

  logic [V6_COUNT-1:0] hits;

  always_comb begin
    for (int k = 0; k < V6_COUNT; k++) begin
      hits[k] = ((addr_high & mask64(V6_LEN[k])) == (V6_HI[k] & mask64(V6_LEN[k])))
             && ((addr_low & ((V6_LEN[k] > 8'd64) ? mask64(V6_LEN[k] - 8'd64) : 64'h0))
                 == (V6_LO[k] & ((V6_LEN[k] > 8'd64) ? mask64(V6_LEN[k] - 8'd64) : 64'h0)));
    end
  end

  always_comb begin
    result = '0;
    for (int k = V6_COUNT - 1; k >= 0; k--) begin
      if (hits[k]) begin
        result.hit   = 1'b1;
        result.entry = 4'(k);
        result.plen  = V6_LEN[k];
      end
    end
  end

endmodule

`default_nettype wire

[dv/ip_prefix_blocklist_filter_tb.sv]
// Self-checking testbench for ip_prefix_blocklist_filter: directed and random requests with
// random source gaps and sink stalls; a scoreboard predicts each verdict and checks it in order.
// Depends on ipbf_pkg (verdict_t) and the filter RTL.
`timescale 1ns / 1ps

module ip_prefix_blocklist_filter_tb;
  import ipbf_pkg::*;

  localparam int unsigned V4_ENTRIES  = 10;
  localparam int unsigned V6_ENTRIES  = 7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 4;

  typedef struct packed {
    logic       allowed;
    verdict_t   verdict;
    logic [3:0] entry;
    logic [7:0] plen;
  } verdict_rec_t;

  class verdict_checker;
    verdict_rec_t pending_verdicts[$];
    int unsigned  errors = 0;

    // {length, network}
    static function logic [39:0] v4_entry(int unsigned k);
      case (k)
        0: return {8'd8,  32'h0000_0000};
        1: return {8'd8,  32'h0A00_0000};
        2: return {8'd10, 32'h6440_0000};
        3: return {8'd12, 32'hAC10_0000};
        4: return {8'd16, 32'hC0A8_0000};
        5: return {8'd8,  32'h7F00_0000};
        6: return {8'd16, 32'hA9FE_0000};
        7: return {8'd15, 32'hC612_0000};
        8: return {8'd4,  32'hE000_0000};
        default: return {8'd4, 32'hF000_0000};
      endcase
    endfunction

    static function logic [135:0] v6_entry(int unsigned k);
      case (k)
        0: return {8'd128, 128'h0000_0000_0000_0000_0000_0000_0000_0001};
        1: return {8'd96,  128'h0064_FF9B_0000_0000_0000_0000_0000_0000};
        2: return {8'd64,  128'h0100_0000_0000_0000_0000_0000_0000_0000};
        3: return {8'd7,   128'hFC00_0000_0000_0000_0000_0000_0000_0000};
        4: return {8'd10,  128'hFE80_0000_0000_0000_0000_0000_0000_0000};
        5: return {8'd8,   128'hFF00_0000_0000_0000_0000_0000_0000_0000};
        default: return {8'd96, 128'h0000_0000_0000_0000_0000_FFFF_0000_0000};
      endcase
    endfunction

    function verdict_rec_t predict_verdict(logic [127:0] a, logic v, logic blk);
      verdict_rec_t r;
      logic [39:0]  e4;
      logic [135:0] e6;
      logic [31:0]  m4;
      logic [127:0] m6;
      logic         done;
      int unsigned  k;
      r = '0;
      r.verdict = VERDICT_ALLOWED;
      done = 1'b0;
      if (blk) begin
        r.verdict = VERDICT_FORCED;
      end else if (!v) begin
        r.verdict = VERDICT_INVALID;
      end else if (a[127:32] == {80'h0, 16'hFFFF}) begin
        for (k = 0; k < V4_ENTRIES; k++) begin
          e4 = v4_entry(k);
          m4 = 32'hFFFF_FFFF << (32 - e4[39:32]);
          if (!done && ((a[31:0] & m4) == (e4[31:0] & m4))) begin
            done = 1'b1;
            r.verdict = VERDICT_V4_HIT;
            r.entry = k[3:0];
            r.plen = e4[39:32];
          end
        end
      end else begin
        for (k = 0; k < V6_ENTRIES; k++) begin
          e6 = v6_entry(k);
          m6 = {128{1'b1}} << (128 - e6[135:128]);
          if (!done && ((a & m6) == (e6[127:0] & m6))) begin
            done = 1'b1;
            r.verdict = VERDICT_V6_HIT;
            r.entry = k[3:0];
            r.plen = e6[135:128];
          end
        end
      end
      r.allowed = (r.verdict == VERDICT_ALLOWED);
      return r;
    endfunction

    function void note_request(logic [63:0] hi, logic [63:0] lo, logic v, logic blk);
      pending_verdicts.push_back(predict_verdict({hi, lo}, v, blk));
    endfunction

    function void field_check(string name, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_verdict(verdict_rec_t got);
      verdict_rec_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %0h", $time, got);
        return;
      end
      want = pending_verdicts.pop_front();
      field_check("allowed", 8'(want.allowed), 8'(got.allowed));
      field_check("verdict", 8'(want.verdict), 8'(got.verdict));
      field_check("hit_entry", 8'(want.entry), 8'(got.entry));
      field_check("hit_prefix_len", want.plen, got.plen);
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic        addr_valid = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        allowed;
  logic [2:0]  verdict;
  logic [3:0]  hit_entry;
  logic [7:0]  hit_prefix_len;

  logic        blk_shadow = 1'b0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  verdict_checker board = new;

  ip_prefix_blocklist_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .addr_high     (addr_high),
    .addr_low      (addr_low),
    .addr_valid    (addr_valid),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .allowed       (allowed),
    .verdict       (verdict),
    .hit_entry     (hit_entry),
    .hit_prefix_len(hit_prefix_len)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    verdict_rec_t got;
    cycle_count++;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        board.note_request(addr_high, addr_low, addr_valid, blk_shadow);
      end
      if (rsp_valid && !rsp_stall) begin
        got.allowed = allowed;
        got.verdict = verdict_t'(verdict);
        got.entry = hit_entry;
        got.plen = hit_prefix_len;
        board.check_verdict(got);
      end
    end
  end

  // sink stalls: mostly short, a few long
  always @(posedge clk) begin
    int unsigned r;
    if (stall_left != 0) begin
      stall_left--;
    end else if (!sink_idle) begin
      rsp_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        rsp_stall <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else if (r < 90) begin
        rsp_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        rsp_stall <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("ip_prefix_blocklist_filter_tb: errors");
    $finish;
  end

  function automatic int unsigned source_gap();
    int unsigned r;
    if (!src_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic [127:0] a, logic v);
    int unsigned gap;
    gap = source_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    addr_high <= a[127:64];
    addr_low <= a[63:0];
    addr_valid <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_all(logic v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    blk_shadow <= v;
  endtask

  function automatic logic [127:0] mapped(logic [31:0] v4);
    return {80'h0, 16'hFFFF, v4};
  endfunction

  task automatic random_request();
    logic [127:0] a;
    logic [127:0] m6;
    logic [135:0] e6;
    logic [39:0]  e4;
    logic [31:0]  m4;
    logic [31:0]  v4;
    logic         v;
    int unsigned  pick;
    int unsigned  k;
    a = {$urandom, $urandom, $urandom, $urandom};
    v = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      k = $urandom_range(0, V4_ENTRIES);
      v4 = $urandom;
      if (k < V4_ENTRIES) begin
        e4 = verdict_checker::v4_entry(k);
        m4 = 32'hFFFF_FFFF << (32 - e4[39:32]);
        v4 = (e4[31:0] & m4) | (v4 & ~m4);
        if ($urandom_range(0, 4) == 0) begin
          v4 = v4 ^ (32'h1 << (31 - $urandom_range(0, e4[39:32] - 1)));
        end
      end
      a = mapped(v4);
    end else if (pick < 75) begin
      k = $urandom_range(0, V6_ENTRIES - 1);
      e6 = verdict_checker::v6_entry(k);
      m6 = {128{1'b1}} << (128 - e6[135:128]);
      a = (e6[127:0] & m6) | (a & ~m6);
      if ($urandom_range(0, 4) == 0) begin
        a = a ^ (128'h1 << (127 - $urandom_range(0, e6[135:128] - 1)));
      end
    end else if (pick < 87) begin
      // one bit off the mapped form
      a = mapped($urandom) ^ (128'h1 << $urandom_range(32, 127));
    end
    send_request(a, v);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      random_request();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_block_all(1'b0);
    send_request(128'h0, 1'b1);
    send_request(128'h1, 1'b1);
    send_request(128'h1, 1'b0);
    send_request({128{1'b1}}, 1'b1);
    send_request({128{1'b1}}, 1'b0);
    send_request(128'h0064_FF9B_0000_0000_0000_0000_0102_0304, 1'b1);
    send_request(128'h0100_0000_0000_0000_0000_0000_0000_0005, 1'b1);
    send_request(128'hFD12_0000_0000_0000_0000_0000_0000_0000, 1'b1);
    send_request(128'hFEBF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(128'hFEC0_0000_0000_0000_0000_0000_0000_0000, 1'b1);
    send_request(mapped(32'h0001_0203), 1'b1);
    send_request(mapped(32'h0AFF_FFFF), 1'b1);
    send_request(mapped(32'h647F_FFFF), 1'b1);
    send_request(mapped(32'h6480_0000), 1'b1);
    send_request(mapped(32'hAC1F_0001), 1'b1);
    send_request(mapped(32'hC0A8_0101), 1'b1);
    send_request(mapped(32'h7F00_0001), 1'b1);
    send_request(mapped(32'hA9FE_0101), 1'b1);
    send_request(mapped(32'hC613_FFFF), 1'b1);
    send_request(mapped(32'hE000_0001), 1'b1);
    send_request(mapped(32'hFFFF_FFFF), 1'b1);
    send_request(mapped(32'h0808_0808), 1'b1);
    send_request(mapped(32'h0808_0808) | (128'h1 << 100), 1'b1);
    send_request(128'h0000_0000_0000_0000_0001_FFFF_0A00_0001, 1'b1);
    drain();

    write_block_all(1'b1);
    send_request(128'h0, 1'b1);
    send_request(128'h0, 1'b0);
    send_request(mapped(32'h0808_0808), 1'b1);
    drain();

    write_block_all(1'b0);
    random_phase(450);
    write_block_all(1'b1);
    random_phase(100);
    write_block_all(1'b0);
    random_phase(400);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("ip_prefix_blocklist_filter_tb: clean");
    end else begin
      $display("ip_prefix_blocklist_filter_tb: errors");
    end
    $finish;
  end

endmodule
